### src/nswg_pkg.sv
// shared types and codes for the numeric symbiont world generation unit
package nswg_pkg;

  localparam int unsigned WorldMax = 128;
  localparam int unsigned AddrW = $clog2(WorldMax);

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [1:0] NORM_BASIC       = 2'd0;
  localparam logic [1:0] NORM_SYMBIOTIC   = 2'd1;
  localparam logic [1:0] NORM_EXCLUSION   = 2'd2;
  localparam logic [1:0] NORM_CONDITIONAL = 2'd3;

  localparam logic [7:0] CFG_RULE_NORM  = 8'd0;
  localparam logic [7:0] CFG_WORLD_SIZE = 8'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         cell_index;
    logic signed [15:0] cell_value;
    logic               cell_is_mark;
  } in_t;

  typedef struct packed {
    logic [6:0]         read_index;
    logic signed [15:0] read_value;
    logic               read_is_mark;
  } out_t;

  typedef struct packed {
    logic               mark;
    logic signed [15:0] val;
  } cell_t;

endpackage

### src/numeric_symbiont_world_generation_unit.sv
// numeric symbiont world: cell store, cell access and generation advance
// After reset a pass over every cell clears both world memories; no input word
// is taken until it ends. A write word goes from the idle state straight to the
// response state; a read word passes through a read state first, since it waits
// on the registered memory port. An advance takes a pass over the world_size
// cells (at most 128; the basic norm reads each cell and then the cell at its
// offset, the other norms follow a chain of levels from each cell and may run a
// nearest-number scan), then a sweep that copies the next world memory into the
// current one and clears it, and then gives the result. One result word is
// produced per input word; the next input word is taken while a result still
// waits at the output, and that word's result then waits for the output. Each
// memory has a single read port.
module numeric_symbiont_world_generation_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  nswg_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nswg_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i
);
  import nswg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RESP,
    ST_B_RD, ST_B_W1, ST_B_W2,
    ST_C_RD, ST_C_CHK, ST_C_J, ST_C_PL, ST_C_WR, ST_SC_ISS, ST_SC_CHK,
    ST_CP, ST_CLR
  } state_e;

  cell_t cur_mem [WorldMax];
  cell_t nxt_mem [WorldMax];

  state_e state_q;
  logic [1:0] norm_q;
  logic [7:0] wsize_q;
  logic [7:0] n_q, i_q, level_q, k_q;
  logic signed [17:0] j_q, p_q, lp_q;
  logic signed [15:0] v_q, w_q, lv_q, ab_val_q;
  logic ab_num_q, dir_right_q, cp_pend_q;
  logic [AddrW-1:0] c_q;
  cell_t wd_q, cur_rd, nxt_rd;
  out_t res_q, out_q;
  logic out_valid_q;

  logic [AddrW-1:0] cur_raddr, nxt_raddr, cur_waddr, nxt_waddr;
  logic cur_we, nxt_we;
  cell_t cur_wdata, nxt_wdata;

  logic in_fire;
  logic signed [17:0] i_s, n_s;
  logic signed [15:0] w_b, wc_b;
  logic signed [17:0] c_b, sum_b, j_next;
  logic signed [15:0] sum_sat, mut_dist;
  logic cur_is_num;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign i_s = $signed({10'b0, i_q});
  assign n_s = $signed({10'b0, n_q});
  assign cur_is_num = !cur_rd.mark && (cur_rd.val != 16'sd0);
  assign w_b  = cur_rd.mark ? 16'sd0 : cur_rd.val;
  assign wc_b = cur_rd.mark ? 16'sd0 : cur_rd.val;
  assign c_b  = i_s + 18'(w_b);
  assign sum_b = 18'(nxt_rd.val) + 18'(w_q) - 18'(wc_b);
  assign sum_sat = (sum_b > 18'sd32767) ? 16'sh7fff :
                   (sum_b < -18'sd32768) ? 16'sh8000 : sum_b[15:0];
  assign j_next = i_s + 18'(ab_val_q);
  assign mut_dist = 16'(p_q - lp_q);

  // memory address and write selection
  always_comb begin
    cur_raddr = in_data_i.cell_index;
    nxt_raddr = i_q[AddrW-1:0];
    cur_we = 1'b0;
    cur_waddr = in_data_i.cell_index;
    cur_wdata = '0;
    nxt_we = 1'b0;
    nxt_waddr = i_q[AddrW-1:0];
    nxt_wdata = '0;
    case (state_q)
      ST_IDLE: begin
        cur_we = in_fire && (in_data_i.mode == MODE_WRITE);
        cur_wdata.mark = in_data_i.cell_is_mark;
        cur_wdata.val = in_data_i.cell_is_mark ? 16'sd0 : in_data_i.cell_value;
      end
      ST_B_RD, ST_C_RD: begin
        cur_raddr = i_q[AddrW-1:0];
      end
      ST_B_W1: begin
        nxt_we = 1'b1;
        nxt_wdata.val = (nxt_rd.val != 16'sd0) ? nxt_rd.val : w_b;
        cur_raddr = c_b[AddrW-1:0];
        nxt_raddr = c_b[AddrW-1:0];
      end
      ST_B_W2: begin
        nxt_we = 1'b1;
        nxt_waddr = c_q;
        nxt_wdata.val = (nxt_rd.val != 16'sd0) ? sum_sat : w_q;
      end
      ST_C_J: begin
        cur_raddr = j_q[AddrW-1:0];
        nxt_raddr = j_q[AddrW-1:0];
      end
      ST_C_WR: begin
        nxt_we = 1'b1;
        nxt_waddr = j_q[AddrW-1:0];
        nxt_wdata = wd_q;
      end
      ST_SC_ISS: begin
        cur_raddr = p_q[AddrW-1:0];
      end
      ST_CP: begin
        nxt_raddr = k_q[AddrW-1:0];
        nxt_we = !k_q[AddrW];
        nxt_waddr = k_q[AddrW-1:0];
        cur_we = cp_pend_q;
        cur_waddr = AddrW'(k_q - 8'd1);
        cur_wdata = nxt_rd;
      end
      // blank both worlds after reset
      ST_CLR: begin
        cur_we = 1'b1;
        cur_waddr = k_q[AddrW-1:0];
        nxt_we = 1'b1;
        nxt_waddr = k_q[AddrW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    cur_rd <= cur_mem[cur_raddr];
    nxt_rd <= nxt_mem[nxt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      norm_q <= NORM_BASIC;
      wsize_q <= 8'd10;
      out_valid_q <= 1'b0;
      cp_pend_q <= 1'b0;
      n_q <= '0;
      i_q <= '0;
      level_q <= '0;
      k_q <= '0;
      dir_right_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_RULE_NORM) norm_q <= cfg_data_i[1:0];
        else if (cfg_index_i == CFG_WORLD_SIZE) wsize_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !(state_q == ST_RESP)) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          if (k_q == 8'(WorldMax - 1)) begin
            k_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            k_q <= k_q + 8'd1;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data_i.mode)
              MODE_WRITE: begin
                res_q <= '{read_index: in_data_i.cell_index,
                           read_value: in_data_i.cell_is_mark ? 16'sd0
                                                              : in_data_i.cell_value,
                           read_is_mark: in_data_i.cell_is_mark};
                state_q <= ST_RESP;
              end
              MODE_READ: begin
                res_q <= '{read_index: in_data_i.cell_index,
                           read_value: 16'sd0, read_is_mark: 1'b0};
                state_q <= ST_RD;
              end
              MODE_ADVANCE: begin
                res_q <= '0;
                n_q <= (wsize_q > 8'(WorldMax)) ? 8'(WorldMax) : wsize_q;
                i_q <= '0;
                state_q <= (norm_q == NORM_BASIC) ? ST_B_RD : ST_C_RD;
              end
              default: begin
                res_q <= '0;
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_RD: begin
          res_q <= '{read_index: res_q.read_index, read_value: cur_rd.val,
                     read_is_mark: cur_rd.mark};
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_q <= res_q;
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        // basic norm: own cell then the cell at the offset
        ST_B_RD: begin
          if (i_q >= n_q) begin
            k_q <= '0;
            cp_pend_q <= 1'b0;
            state_q <= ST_CP;
          end else begin
            state_q <= ST_B_W1;
          end
        end
        ST_B_W1: begin
          w_q <= w_b;
          c_q <= c_b[AddrW-1:0];
          if (w_b != 16'sd0 && !c_b[17] && c_b < n_s) begin
            state_q <= ST_B_W2;
          end else begin
            i_q <= i_q + 8'd1;
            state_q <= ST_B_RD;
          end
        end
        ST_B_W2: begin
          i_q <= i_q + 8'd1;
          state_q <= ST_B_RD;
        end
        // chained norms
        ST_C_RD: begin
          if (i_q >= n_q) begin
            k_q <= '0;
            cp_pend_q <= 1'b0;
            state_q <= ST_CP;
          end else begin
            state_q <= ST_C_CHK;
          end
        end
        ST_C_CHK: begin
          v_q <= cur_rd.val;
          j_q <= i_s + 18'(cur_rd.val);
          level_q <= 8'd1;
          if (cur_is_num) begin
            state_q <= ST_C_J;
          end else begin
            i_q <= i_q + 8'd1;
            state_q <= ST_C_RD;
          end
        end
        ST_C_J: begin
          if (j_q[17] || j_q >= n_s || level_q > n_q) begin
            i_q <= i_q + 8'd1;
            state_q <= ST_C_RD;
          end else begin
            state_q <= ST_C_PL;
          end
        end
        ST_C_PL: begin
          ab_num_q <= cur_is_num;
          ab_val_q <= cur_rd.val;
          if (norm_q == NORM_SYMBIOTIC) begin
            wd_q <= '{mark: 1'b0, val: v_q};
            state_q <= ST_C_WR;
          end else if (!nxt_rd.mark && nxt_rd.val == 16'sd0) begin
            wd_q <= '{mark: 1'b0, val: v_q};
            state_q <= ST_C_WR;
          end else if (!nxt_rd.mark && nxt_rd.val == v_q) begin
            wd_q <= nxt_rd;
            state_q <= ST_C_WR;
          end else if (norm_q == NORM_EXCLUSION || cur_is_num) begin
            wd_q <= '{mark: 1'b1, val: 16'sd0};
            state_q <= ST_C_WR;
          end else begin
            // distance mutation: look for the nearest numbers on both sides
            dir_right_q <= 1'b0;
            p_q <= j_q - 18'sd1;
            state_q <= ST_SC_ISS;
          end
        end
        ST_SC_ISS: begin
          if (p_q[17] || p_q >= n_s) begin
            wd_q <= '{mark: 1'b1, val: 16'sd0};
            state_q <= ST_C_WR;
          end else begin
            state_q <= ST_SC_CHK;
          end
        end
        ST_SC_CHK: begin
          if (cur_is_num) begin
            if (!dir_right_q) begin
              lp_q <= p_q;
              lv_q <= cur_rd.val;
              dir_right_q <= 1'b1;
              p_q <= j_q + 18'sd1;
              state_q <= ST_SC_ISS;
            end else begin
              wd_q <= '{mark: 1'b0,
                        val: ((!lv_q[15] && lv_q != 16'sd0) ==
                              (!cur_rd.val[15] && cur_rd.val != 16'sd0)) ? mut_dist
                                                                         : -mut_dist};
              state_q <= ST_C_WR;
            end
          end else begin
            p_q <= dir_right_q ? p_q + 18'sd1 : p_q - 18'sd1;
            state_q <= ST_SC_ISS;
          end
        end
        ST_C_WR: begin
          if (!ab_num_q || ab_val_q == v_q ||
              (norm_q != NORM_SYMBIOTIC && j_next == j_q)) begin
            i_q <= i_q + 8'd1;
            state_q <= ST_C_RD;
          end else begin
            j_q <= j_next;
            level_q <= level_q + 8'd1;
            state_q <= ST_C_J;
          end
        end
        // copy next world over current world and clear it
        ST_CP: begin
          if (k_q[AddrW]) begin
            cp_pend_q <= 1'b0;
            res_q <= '0;
            state_q <= ST_RESP;
          end else begin
            cp_pend_q <= 1'b1;
            k_q <= k_q + 8'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
